/* hw/rtl/rsws_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the reservation station.
package rsws_pkg;

  // Default sizes
  localparam int unsigned EntriesDef   = 8;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned TagBitsDef   = 6;

  // Fixed field widths
  localparam int unsigned NOW_W = 16;
  localparam int unsigned LAT_W = 7;
  localparam int unsigned FIN_W = 17;

  localparam logic [LAT_W-1:0] LAT_RESET = LAT_W'(1);

  // APB register map: register i at byte address 4*i
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_EXEC_LATENCY = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    CMD_ISSUE   = 2'd0,
    CMD_BCAST   = 2'd1,
    CMD_EXEC    = 2'd2,
    CMD_RELEASE = 2'd3
  } rsws_cmd_e;

  // Control part of the transaction packet moving down the cell chain
  typedef struct packed {
    logic      vld;
    rsws_cmd_e cmd;
    logic      hit;       // issue claimed a slot / execute has a candidate
    logic      any_busy;  // OR of busy bits of the cells already passed
  } rsws_ctl_t;

  // Per-slot status seen by the top level
  typedef struct packed {
    logic busy;
    logic sched;
  } rsws_stat_t;

endpackage

/* hw/rtl/rsws_if.sv */
`timescale 1ns / 1ps
// Command and result channel interfaces of the reservation station.
interface rsws_in_if
  import rsws_pkg::*;
#(
  parameter int unsigned IDX_W      = 3,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned TAG_BITS   = TagBitsDef
);
  logic                  valid;
  logic                  ready;
  rsws_cmd_e             command;
  logic [NOW_W-1:0]      now;
  logic                  j_waiting;
  logic [TAG_BITS-1:0]   j_tag;
  logic [VALUE_BITS-1:0] j_value;
  logic                  k_waiting;
  logic [TAG_BITS-1:0]   k_tag;
  logic [VALUE_BITS-1:0] k_value;
  logic [TAG_BITS-1:0]   cdb_tag;
  logic [VALUE_BITS-1:0] cdb_value;
  logic [IDX_W-1:0]      slot;

  modport source (
    output valid, command, now, j_waiting, j_tag, j_value, k_waiting, k_tag, k_value,
           cdb_tag, cdb_value, slot,
    input  ready
  );
  modport sink (
    input  valid, command, now, j_waiting, j_tag, j_value, k_waiting, k_tag, k_value,
           cdb_tag, cdb_value, slot,
    output ready
  );
endinterface

interface rsws_out_if
  import rsws_pkg::*;
#(
  parameter int unsigned IDX_W      = 3,
  parameter int unsigned VALUE_BITS = ValueBitsDef
);
  logic                  valid;
  logic                  ready;
  logic                  index_valid;
  logic [IDX_W-1:0]      entry_index;
  logic [FIN_W-1:0]      finish_time;
  logic [VALUE_BITS-1:0] operand_j;
  logic [VALUE_BITS-1:0] operand_k;
  logic                  any_pending;

  modport source (
    output valid, index_valid, entry_index, finish_time, operand_j, operand_k, any_pending,
    input  ready
  );
  modport sink (
    input  valid, index_valid, entry_index, finish_time, operand_j, operand_k, any_pending,
    output ready
  );
endinterface

/* hw/rtl/reservation_station_wakeup_select.sv */
`timescale 1ns / 1ps
// Reservation station: a chain of slot cells that a command transaction walks
// through one cell per cycle. Issue claims the lowest free slot, broadcast
// wakes waiting sources with a matching tag, execute picks the oldest ready
// slot issued before now (lowest index on ties) and release frees a slot.
// Flow: a command is accepted only while the chain is empty; it passes
// cell 0 at the acceptance edge and then the register of each further
// cell on its way to the result register, so a new transaction is taken
// only once the last one has left the chain. The result register decouples
// the result side: a new command may be accepted while a result is still
// waiting to be taken, and a packet that reaches the end of the chain waits
// there until the result register frees up. exec_latency is written
// through the APB port (byte address 0); a value of 0 acts as 1. No
// clearing pass is needed after reset.
module reservation_station_wakeup_select
  import rsws_pkg::*;
#(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned TAG_BITS   = TagBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rsws_in_if.sink               in_i,
  rsws_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // ---------------------------------------------------------------- config
  logic [LAT_W-1:0]     lat_q;
  logic [LAT_W-1:0]     lat_eff;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_idx == REG_EXEC_LATENCY) ? APB_DATA_W'(lat_q) : '0;
  assign lat_eff = (lat_q == '0) ? LAT_W'(1) : lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= LAT_RESET;
    end else if (cfg_wr && (reg_idx == REG_EXEC_LATENCY)) begin
      lat_q <= pwdata[LAT_W-1:0];
    end
  end

  // ------------------------------------------------------------ cell chain
  rsws_ctl_t             ctl_w     [ENTRIES+1];
  logic [NOW_W-1:0]      now_w     [ENTRIES+1];
  logic                  jw_w      [ENTRIES+1];
  logic [TAG_BITS-1:0]   jt_w      [ENTRIES+1];
  logic [VALUE_BITS-1:0] jv_w      [ENTRIES+1];
  logic                  kw_w      [ENTRIES+1];
  logic [TAG_BITS-1:0]   kt_w      [ENTRIES+1];
  logic [VALUE_BITS-1:0] kv_w      [ENTRIES+1];
  logic [TAG_BITS-1:0]   cdb_tag_w [ENTRIES+1];
  logic [VALUE_BITS-1:0] cdb_val_w [ENTRIES+1];
  logic [IDX_W-1:0]      slot_w    [ENTRIES+1];
  logic [IDX_W-1:0]      idx_w     [ENTRIES+1];
  logic [NOW_W-1:0]      best_w    [ENTRIES+1];
  rsws_stat_t            stat_w    [ENTRIES];

  logic [ENTRIES-1:0] pkt_vec;    // packet position in the chain
  logic [ENTRIES-1:0] busy_vec;
  logic [ENTRIES-1:0] sched_vec;
  logic [ENTRIES-1:0] stall_vec;

  logic       in_acc;
  logic       stall;
  logic       done;
  logic       exec_hit;
  logic       out_valid_q;
  rsws_ctl_t  tail;

  assign in_i.ready = ~|pkt_vec;
  assign in_acc     = in_i.valid && in_i.ready;

  // chain head: a fresh packet; execute starts its search bound at now
  assign ctl_w[0].vld      = in_acc;
  assign ctl_w[0].cmd      = in_i.command;
  assign ctl_w[0].hit      = 1'b0;
  assign ctl_w[0].any_busy = 1'b0;
  assign now_w[0]          = in_i.now;
  assign jw_w[0]           = in_i.j_waiting;
  assign jt_w[0]           = in_i.j_tag;
  assign jv_w[0]           = in_i.j_value;
  assign kw_w[0]           = in_i.k_waiting;
  assign kt_w[0]           = in_i.k_tag;
  assign kv_w[0]           = in_i.k_value;
  assign cdb_tag_w[0]      = in_i.cdb_tag;
  assign cdb_val_w[0]      = in_i.cdb_value;
  assign slot_w[0]         = in_i.slot;
  assign idx_w[0]          = '0;
  assign best_w[0]         = in_i.now;

  // only the last cell holds its packet while the result register is full
  assign stall_vec = ENTRIES'(stall) << (ENTRIES - 1);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rsws_cell #(
      .IDX_W      (IDX_W),
      .VALUE_BITS (VALUE_BITS),
      .TAG_BITS   (TAG_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stall_i     (stall_vec[g]),
      .sched_set_i (exec_hit),
      .sched_idx_i (idx_w[ENTRIES]),
      .ctl_i       (ctl_w[g]),
      .now_i       (now_w[g]),
      .jw_i        (jw_w[g]),
      .jt_i        (jt_w[g]),
      .jv_i        (jv_w[g]),
      .kw_i        (kw_w[g]),
      .kt_i        (kt_w[g]),
      .kv_i        (kv_w[g]),
      .cdb_tag_i   (cdb_tag_w[g]),
      .cdb_val_i   (cdb_val_w[g]),
      .slot_i      (slot_w[g]),
      .idx_i       (idx_w[g]),
      .best_i      (best_w[g]),
      .ctl_o       (ctl_w[g+1]),
      .now_o       (now_w[g+1]),
      .jw_o        (jw_w[g+1]),
      .jt_o        (jt_w[g+1]),
      .jv_o        (jv_w[g+1]),
      .kw_o        (kw_w[g+1]),
      .kt_o        (kt_w[g+1]),
      .kv_o        (kv_w[g+1]),
      .cdb_tag_o   (cdb_tag_w[g+1]),
      .cdb_val_o   (cdb_val_w[g+1]),
      .slot_o      (slot_w[g+1]),
      .idx_o       (idx_w[g+1]),
      .best_o      (best_w[g+1]),
      .stat_o      (stat_w[g])
    );
    assign pkt_vec[g]   = ctl_w[g+1].vld;
    assign busy_vec[g]  = stat_w[g].busy;
    assign sched_vec[g] = stat_w[g].sched;
  end

  // ----------------------------------------------------------- completion
  // The selected slot is marked scheduled when the packet leaves the chain,
  // after every cell has had its say.
  assign tail     = ctl_w[ENTRIES];
  assign stall    = tail.vld && out_valid_q && !out_o.ready;
  assign done     = tail.vld && !stall;
  assign exec_hit = done && (tail.cmd == CMD_EXEC) && tail.hit;

  logic [FIN_W-1:0]      fin;
  logic                  index_valid_q;
  logic [IDX_W-1:0]      entry_index_q;
  logic [FIN_W-1:0]      finish_time_q;
  logic [VALUE_BITS-1:0] operand_j_q, operand_k_q;
  logic                  any_pending_q;
  logic                  exec_sel;

  assign fin      = FIN_W'(now_w[ENTRIES]) + FIN_W'(lat_eff) - FIN_W'(1);
  assign exec_sel = (tail.cmd == CMD_EXEC) && tail.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      index_valid_q <= tail.hit;
      entry_index_q <= idx_w[ENTRIES];
      finish_time_q <= exec_sel ? fin : '0;
      operand_j_q   <= exec_sel ? jv_w[ENTRIES] : '0;
      operand_k_q   <= exec_sel ? kv_w[ENTRIES] : '0;
      any_pending_q <= tail.any_busy;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.index_valid = index_valid_q;
  assign out_o.entry_index = entry_index_q;
  assign out_o.finish_time = finish_time_q;
  assign out_o.operand_j   = operand_j_q;
  assign out_o.operand_k   = operand_k_q;
  assign out_o.any_pending = any_pending_q;

  // ----------------------------------------------------------- assertions
  // at most one transaction travels the chain
  a_one_packet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pkt_vec))
    else $error("more than one transaction in the cell chain");

  // an execute pick is scheduled once it leaves the chain
  a_exec_sched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_hit |=> sched_vec[$past(idx_w[ENTRIES])])
    else $error("selected slot not marked scheduled");

  // a successful issue leaves the claimed slot busy
  a_issue_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && (tail.cmd == CMD_ISSUE) && tail.hit) |=> busy_vec[$past(idx_w[ENTRIES])])
    else $error("issued slot not busy");

  // with nothing in flight, the pending flag reflects the slot state
  a_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (pkt_vec == '0)) |-> (any_pending_q == (|busy_vec)))
    else $error("any_pending disagrees with busy slots");

endmodule

/* hw/rtl/rsws_cell.sv */
`timescale 1ns / 1ps
// One slot of the reservation station, acting on the packet passing through it.
module rsws_cell
  import rsws_pkg::*;
#(
  parameter int unsigned IDX_W      = 3,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned TAG_BITS   = TagBitsDef,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  stall_i,
  input  logic                  sched_set_i,
  input  logic [IDX_W-1:0]      sched_idx_i,
  input  rsws_ctl_t             ctl_i,
  input  logic [NOW_W-1:0]      now_i,
  input  logic                  jw_i,
  input  logic [TAG_BITS-1:0]   jt_i,
  input  logic [VALUE_BITS-1:0] jv_i,
  input  logic                  kw_i,
  input  logic [TAG_BITS-1:0]   kt_i,
  input  logic [VALUE_BITS-1:0] kv_i,
  input  logic [TAG_BITS-1:0]   cdb_tag_i,
  input  logic [VALUE_BITS-1:0] cdb_val_i,
  input  logic [IDX_W-1:0]      slot_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [NOW_W-1:0]      best_i,
  output rsws_ctl_t             ctl_o,
  output logic [NOW_W-1:0]      now_o,
  output logic                  jw_o,
  output logic [TAG_BITS-1:0]   jt_o,
  output logic [VALUE_BITS-1:0] jv_o,
  output logic                  kw_o,
  output logic [TAG_BITS-1:0]   kt_o,
  output logic [VALUE_BITS-1:0] kv_o,
  output logic [TAG_BITS-1:0]   cdb_tag_o,
  output logic [VALUE_BITS-1:0] cdb_val_o,
  output logic [IDX_W-1:0]      slot_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic [NOW_W-1:0]      best_o,
  output rsws_stat_t            stat_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  // slot state
  logic                  busy_q, busy_d, sched_q, sched_d;
  logic                  jw_q, jw_d, kw_q, kw_d;
  logic [NOW_W-1:0]      itime_q, itime_d;
  logic [TAG_BITS-1:0]   jt_q, jt_d, kt_q, kt_d;
  logic [VALUE_BITS-1:0] jv_q, jv_d, kv_q, kv_d;

  // outgoing packet
  rsws_ctl_t             p_ctl_q, p_ctl_d;
  logic [IDX_W-1:0]      p_idx_q, p_idx_d;
  logic [NOW_W-1:0]      p_best_q, p_best_d;
  logic [VALUE_BITS-1:0] p_jv_q, p_jv_d, p_kv_q, p_kv_d;
  logic [NOW_W-1:0]      p_now_q;
  logic                  p_jw_q, p_kw_q;
  logic [TAG_BITS-1:0]   p_jt_q, p_kt_q, p_cdb_tag_q;
  logic [VALUE_BITS-1:0] p_cdb_val_q;
  logic [IDX_W-1:0]      p_slot_q;

  logic ready_src;

  assign ready_src = busy_q && !sched_q && !jw_q && !kw_q;

  always_comb begin
    busy_d   = busy_q;
    sched_d  = sched_q;
    jw_d     = jw_q;
    kw_d     = kw_q;
    itime_d  = itime_q;
    jt_d     = jt_q;
    jv_d     = jv_q;
    kt_d     = kt_q;
    kv_d     = kv_q;
    p_ctl_d  = ctl_i;
    p_idx_d  = idx_i;
    p_best_d = best_i;
    p_jv_d   = jv_i;
    p_kv_d   = kv_i;
    if (ctl_i.vld) begin
      unique case (ctl_i.cmd)
        CMD_ISSUE: begin
          if (!ctl_i.hit && !busy_q) begin
            busy_d      = 1'b1;
            sched_d     = 1'b0;
            itime_d     = now_i;
            jw_d        = jw_i;
            jt_d        = jt_i;
            jv_d        = jv_i;
            kw_d        = kw_i;
            kt_d        = kt_i;
            kv_d        = kv_i;
            p_ctl_d.hit = 1'b1;
            p_idx_d     = MY_IDX;
          end
        end
        CMD_BCAST: begin
          if (busy_q && !sched_q) begin
            if (jw_q && (jt_q == cdb_tag_i)) begin
              jw_d = 1'b0;
              jv_d = cdb_val_i;
            end
            if (kw_q && (kt_q == cdb_tag_i)) begin
              kw_d = 1'b0;
              kv_d = cdb_val_i;
            end
          end
        end
        CMD_EXEC: begin
          // strict compare: earlier cells win ties
          if (ready_src && (itime_q < best_i)) begin
            p_ctl_d.hit = 1'b1;
            p_idx_d     = MY_IDX;
            p_best_d    = itime_q;
            p_jv_d      = jv_q;
            p_kv_d      = kv_q;
          end
        end
        CMD_RELEASE: begin
          if (slot_i == MY_IDX) begin
            busy_d  = 1'b0;
            sched_d = 1'b0;
          end
        end
      endcase
    end
    if (sched_set_i && (sched_idx_i == MY_IDX)) begin
      sched_d = 1'b1;
    end
    p_ctl_d.any_busy = ctl_i.any_busy | busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      sched_q <= 1'b0;
      jw_q    <= 1'b0;
      kw_q    <= 1'b0;
      p_ctl_q <= '0;
    end else begin
      busy_q  <= busy_d;
      sched_q <= sched_d;
      jw_q    <= jw_d;
      kw_q    <= kw_d;
      if (!stall_i) begin
        p_ctl_q <= p_ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    itime_q <= itime_d;
    jt_q    <= jt_d;
    jv_q    <= jv_d;
    kt_q    <= kt_d;
    kv_q    <= kv_d;
    if (!stall_i) begin
      p_idx_q     <= p_idx_d;
      p_best_q    <= p_best_d;
      p_jv_q      <= p_jv_d;
      p_kv_q      <= p_kv_d;
      p_now_q     <= now_i;
      p_jw_q      <= jw_i;
      p_jt_q      <= jt_i;
      p_kw_q      <= kw_i;
      p_kt_q      <= kt_i;
      p_cdb_tag_q <= cdb_tag_i;
      p_cdb_val_q <= cdb_val_i;
      p_slot_q    <= slot_i;
    end
  end

  assign ctl_o     = p_ctl_q;
  assign now_o     = p_now_q;
  assign jw_o      = p_jw_q;
  assign jt_o      = p_jt_q;
  assign jv_o      = p_jv_q;
  assign kw_o      = p_kw_q;
  assign kt_o      = p_kt_q;
  assign kv_o      = p_kv_q;
  assign cdb_tag_o = p_cdb_tag_q;
  assign cdb_val_o = p_cdb_val_q;
  assign slot_o    = p_slot_q;
  assign idx_o     = p_idx_q;
  assign best_o    = p_best_q;

  assign stat_o.busy  = busy_q;
  assign stat_o.sched = sched_q;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the reservation station: command stream, slot predictor and APB setup.
module testbench;
  import rsws_pkg::*;

  localparam int unsigned ENTRIES     = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned TAG_W       = 6;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 242;
  localparam int unsigned LONG_STALL  = 400;   // cycles of receiver hold-off
  localparam int unsigned DRAIN       = 40;    // > chain length + result register
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  // One command transaction as offered on the input channel
  typedef struct packed {
    rsws_cmd_e          command;
    logic [NOW_W-1:0]   now;
    logic               j_waiting;
    logic [TAG_W-1:0]   j_tag;
    logic [VAL_W-1:0]   j_value;
    logic               k_waiting;
    logic [TAG_W-1:0]   k_tag;
    logic [VAL_W-1:0]   k_value;
    logic [TAG_W-1:0]   cdb_tag;
    logic [VAL_W-1:0]   cdb_value;
    logic [IDX_W-1:0]   slot;
  } rs_cmd_t;

  // One slot report as returned on the output channel
  typedef struct packed {
    logic               index_valid;
    logic [IDX_W-1:0]   entry_index;
    logic [FIN_W-1:0]   finish_time;
    logic [VAL_W-1:0]   operand_j;
    logic [VAL_W-1:0]   operand_k;
    logic               any_pending;
  } slot_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // APB side
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rsws_in_if  #(.IDX_W(IDX_W), .VALUE_BITS(VAL_W), .TAG_BITS(TAG_W)) cmd_if ();
  rsws_out_if #(.IDX_W(IDX_W), .VALUE_BITS(VAL_W)) rpt_if ();

  reservation_station_wakeup_select #(
    .ENTRIES   (ENTRIES),
    .VALUE_BITS(VAL_W),
    .TAG_BITS  (TAG_W)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (rpt_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Slot predictor: its own copy of the station contents and of exec_latency.
  // Entries that were never issued are never looked at (only busy slots are).
  // ---------------------------------------------------------------------------
  logic [ENTRIES-1:0] st_busy  = '0;
  logic [ENTRIES-1:0] st_sched = '0;
  logic [ENTRIES-1:0] st_jw    = '0;
  logic [ENTRIES-1:0] st_kw    = '0;
  logic [NOW_W-1:0]   st_issue [ENTRIES];
  logic [TAG_W-1:0]   st_jt    [ENTRIES];
  logic [TAG_W-1:0]   st_kt    [ENTRIES];
  logic [VAL_W-1:0]   st_jv    [ENTRIES];
  logic [VAL_W-1:0]   st_kv    [ENTRIES];
  logic [LAT_W-1:0]   st_latency = LAT_RESET;

  // Applies one accepted command to the station copy and returns its report.
  function automatic slot_report_t apply_command(rs_cmd_t c);
    slot_report_t r;
    logic found;
    logic [NOW_W-1:0] oldest;
    int pick;
    int lat;
    r = '0;
    found = 1'b0;
    oldest = c.now;
    pick = 0;
    case (c.command)
      CMD_ISSUE: begin
        // lowest free slot; a full station leaves everything alone
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && !st_busy[i]) begin
            found = 1'b1;
            st_busy[i] = 1'b1;
            st_sched[i] = 1'b0;
            st_issue[i] = c.now;
            st_jw[i] = c.j_waiting;
            st_jt[i] = c.j_tag;
            st_jv[i] = c.j_value;  // kept even when waiting
            st_kw[i] = c.k_waiting;
            st_kt[i] = c.k_tag;
            st_kv[i] = c.k_value;
            r.index_valid = 1'b1;
            r.entry_index = IDX_W'(i);
          end
        end
      end
      CMD_BCAST: begin
        // only waiting sources of busy, unscheduled slots wake up
        for (int i = 0; i < ENTRIES; i++) begin
          if (st_busy[i] && !st_sched[i]) begin
            if (st_jw[i] && st_jt[i] == c.cdb_tag) begin
              st_jw[i] = 1'b0;
              st_jv[i] = c.cdb_value;
            end
            if (st_kw[i] && st_kt[i] == c.cdb_tag) begin
              st_kw[i] = 1'b0;
              st_kv[i] = c.cdb_value;
            end
          end
        end
      end
      CMD_EXEC: begin
        // oldest ready slot issued strictly before now; strict compare keeps
        // the lowest index on ties
        for (int i = 0; i < ENTRIES; i++) begin
          if (st_busy[i] && !st_sched[i] && !st_jw[i] && !st_kw[i] &&
              st_issue[i] < oldest) begin
            oldest = st_issue[i];
            pick = i;
            found = 1'b1;
          end
        end
        if (found) begin
          lat = (st_latency == '0) ? 1 : int'(st_latency);
          st_sched[pick] = 1'b1;
          r.index_valid = 1'b1;
          r.entry_index = IDX_W'(pick);
          r.finish_time = FIN_W'(int'(c.now) + lat - 1);
          r.operand_j = st_jv[pick];
          r.operand_k = st_kv[pick];
        end
      end
      default: begin
        // release: an in-flight slot loses its scheduled mark as well
        if (int'(c.slot) < ENTRIES) begin
          st_busy[c.slot] = 1'b0;
          st_sched[c.slot] = 1'b0;
        end
      end
    endcase
    r.any_pending = |st_busy;
    return r;
  endfunction

  // Command with random content in every field, then command and time set.
  function automatic rs_cmd_t noise_cmd(rsws_cmd_e op, logic [NOW_W-1:0] at);
    rs_cmd_t c;
    c.command   = op;
    c.now       = at;
    c.j_waiting = 1'($urandom);
    c.j_tag     = TAG_W'($urandom);
    c.j_value   = $urandom;
    c.k_waiting = 1'($urandom);
    c.k_tag     = TAG_W'($urandom);
    c.k_value   = $urandom;
    c.cdb_tag   = TAG_W'($urandom);
    c.cdb_value = $urandom;
    c.slot      = IDX_W'($urandom);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  rs_cmd_t      command_q[$];      // commands not yet offered
  slot_report_t owed_reports[$];   // reports of accepted commands, oldest first
  rs_cmd_t      cmd_on_bus = '0;
  logic         cmd_taken = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  stalls_asked = 0;
  int unsigned  stalls_done = 0;
  int unsigned  stall_left = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endfunction

  // Payload follows the held command; only valid is toggled by the driver.
  assign cmd_if.command   = cmd_on_bus.command;
  assign cmd_if.now       = cmd_on_bus.now;
  assign cmd_if.j_waiting = cmd_on_bus.j_waiting;
  assign cmd_if.j_tag     = cmd_on_bus.j_tag;
  assign cmd_if.j_value   = cmd_on_bus.j_value;
  assign cmd_if.k_waiting = cmd_on_bus.k_waiting;
  assign cmd_if.k_tag     = cmd_on_bus.k_tag;
  assign cmd_if.k_value   = cmd_on_bus.k_value;
  assign cmd_if.cdb_tag   = cmd_on_bus.cdb_tag;
  assign cmd_if.cdb_value = cmd_on_bus.cdb_value;
  assign cmd_if.slot      = cmd_on_bus.slot;

  // ---------------------------------------------------------------------------
  // Driver. Acceptance is seen at the rising edge, where the command is run
  // through the predictor; the next command goes out at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      owed_reports.push_back(apply_command(cmd_on_bus));
      cmd_taken <= 1'b1;
    end else begin
      cmd_taken <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!cmd_if.valid || cmd_taken)) begin
      if (command_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_on_bus = command_q.pop_front();
        cmd_if.valid <= 1'b1;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(negedge clk_i) begin
    if (stalls_asked != stalls_done) begin
      stalls_done = stalls_asked;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      rpt_if.ready <= 1'b0;
    end else begin
      rpt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every report taken is checked field by field against the oldest
  // owed report.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : report_monitor
    slot_report_t want;
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      if (owed_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("report with no command behind it: index_valid %0b entry %0d",
                   rpt_if.index_valid, rpt_if.entry_index);
      end else begin
        want = owed_reports.pop_front();
        compare_field("index_valid", want.index_valid, rpt_if.index_valid);
        compare_field("entry_index", want.entry_index, rpt_if.entry_index);
        compare_field("finish_time", want.finish_time, rpt_if.finish_time);
        compare_field("operand_j", want.operand_j, rpt_if.operand_j);
        compare_field("operand_k", want.operand_k, rpt_if.operand_k);
        compare_field("any_pending", want.any_pending, rpt_if.any_pending);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // APB transfer on the latency register: setup cycle, then access cycle.
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_EXEC_LATENCY, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sender pause: nothing left to offer, nothing on the bus, nothing owed.
  task automatic wait_drained();
    @(posedge clk_i);
    while (command_q.size() != 0 || cmd_if.valid || owed_reports.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: a directed opening, then random phases at different latencies
  // and idling patterns. Latency is only touched while the station is drained.
  // ---------------------------------------------------------------------------
  logic [LAT_W-1:0] lat_tab   [PHASES] = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd33, 7'd5};
  int unsigned      idle_tab  [PHASES] = '{0, 71, 0, 37, 0, 37};
  int unsigned      stall_tab [PHASES] = '{0, 0, 71, 37, 0, 37};

  initial begin
    rs_cmd_t c;
    logic [NOW_W-1:0] stim_now;
    logic [APB_DATA_W-1:0] rd;
    int unsigned pick;

    cmd_if.valid = 1'b0;
    rpt_if.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty station: select finds nothing; releasing a free slot is harmless
    c = noise_cmd(CMD_EXEC, 16'd0);
    command_q.push_back(c);
    c = noise_cmd(CMD_RELEASE, 16'd0);
    c.slot = 3'd7;
    command_q.push_back(c);
    // both sources ready, extreme values and tags
    c = noise_cmd(CMD_ISSUE, 16'd0);
    c.j_waiting = 1'b0; c.j_tag = '1; c.j_value = '1;
    c.k_waiting = 1'b0; c.k_tag = '1; c.k_value = '0;
    command_q.push_back(c);
    // issued at this very cycle: not eligible yet
    c = noise_cmd(CMD_EXEC, 16'd0);
    command_q.push_back(c);
    // both sources waiting, issued at the last cycle number
    c = noise_cmd(CMD_ISSUE, 16'hFFFF);
    c.j_waiting = 1'b1; c.j_tag = '1; c.k_waiting = 1'b1; c.k_tag = '0;
    command_q.push_back(c);
    // wakes j of slot 1; slot 0 carries tag 63 but is not waiting on it
    c = noise_cmd(CMD_BCAST, 16'hFFFF);
    c.cdb_tag = '1; c.cdb_value = 32'hA5A5_A5A5;
    command_q.push_back(c);
    // picks slot 0, finish time at the top of the cycle range
    c = noise_cmd(CMD_EXEC, 16'hFFFF);
    command_q.push_back(c);
    c = noise_cmd(CMD_BCAST, 16'hFFFF);
    c.cdb_tag = '0; c.cdb_value = 32'h5A5A_5A5A;
    command_q.push_back(c);
    // slot 1 now ready but its issue time equals now
    c = noise_cmd(CMD_EXEC, 16'hFFFF);
    command_q.push_back(c);
    // two slots with the same issue time: lower index wins
    repeat (2) begin
      c = noise_cmd(CMD_ISSUE, 16'd100);
      c.j_waiting = 1'b0; c.k_waiting = 1'b0;
      command_q.push_back(c);
    end
    c = noise_cmd(CMD_EXEC, 16'd101);
    command_q.push_back(c);
    // release slot 0 while in flight, then again while already free
    repeat (2) begin
      c = noise_cmd(CMD_RELEASE, 16'd101);
      c.slot = 3'd0;
      command_q.push_back(c);
    end
    // fill the station; the last issue finds it full
    repeat (6) begin
      c = noise_cmd(CMD_ISSUE, 16'd200);
      command_q.push_back(c);
    end
    c = noise_cmd(CMD_EXEC, 16'd201);
    command_q.push_back(c);
    wait_drained();

    stim_now = 16'd300;
    for (int p = 0; p < PHASES; p++) begin
      apb_access(1'b1, APB_DATA_W'(lat_tab[p]), rd);
      st_latency = lat_tab[p];
      apb_access(1'b0, '0, rd);
      compare_field("exec_latency readback", lat_tab[p], rd[LAT_W-1:0]);

      send_idle_pct = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      // first phase: receiver holds off while the sender keeps offering
      if (p == 0) stalls_asked++;

      // Mostly a moving cycle count with a small tag pool, so wakeups and
      // selections really happen; now and then a jump anywhere in time.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        stim_now += NOW_W'($urandom_range(0, 3));
        if ($urandom_range(99) < 3) stim_now = NOW_W'($urandom);
        pick = $urandom_range(99);
        c = noise_cmd(pick < 32 ? CMD_ISSUE : pick < 56 ? CMD_BCAST :
                      pick < 82 ? CMD_EXEC : CMD_RELEASE, stim_now);
        if ($urandom_range(3) != 0) begin
          c.j_tag   = TAG_W'($urandom_range(0, 7));
          c.k_tag   = TAG_W'($urandom_range(0, 7));
          c.cdb_tag = TAG_W'($urandom_range(0, 7));
        end
        command_q.push_back(c);
      end
      wait_drained();
    end

    // let any stray report arrive before the final check
    repeat (DRAIN) @(posedge clk_i);
    if (owed_reports.size() != 0) begin
      mismatches++;
      $display("%0d reports never arrived", owed_reports.size());
    end
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
